### rtl/rpcc_pkg.sv
// Shared types, constants and the microcode program for the rigid-pose unit.
// Used by every module of the block; depends on nothing else.
package rpcc_pkg;

  // default fraction bits of the rotation quaternion
  localparam int ROT_FRAC_BITS_DEF = 30;

  // wide signed width used for saturation and write-back arithmetic
  localparam int SAT_W = 72;

  // microprogram counter
  localparam int PC_W = 6;

  // bounds
  localparam logic signed [SAT_W-1:0] S32_MAX   = SAT_W'(32'sh7fffffff);
  localparam logic signed [SAT_W-1:0] S32_MIN   = SAT_W'(32'sh80000000);
  localparam logic signed [SAT_W-1:0] INNER_MAX = (SAT_W'(1) <<< 32) - SAT_W'(1);

  // configuration register indexes
  localparam logic CFG_DIST_LIMIT = 1'b0;
  localparam logic CFG_MIN_DOT    = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD, OP_COMPOSE, OP_INVERT, OP_CONFLICT
  } op_t;

  // sequencer control per step
  typedef enum logic [1:0] {
    CTL_NEXT, CTL_BR_INV, CTL_BR_CMP, CTL_END
  } ctl_t;

  // multiplier B operand: input quaternion, input translation, inner vector
  typedef enum logic [3:0] {
    B_Q0, B_Q1, B_Q2, B_Q3, B_T0, B_T1, B_T2, B_U0, B_U1, B_U2
  } bsel_t;

  // accumulator destination on the last term of a sum
  typedef enum logic [3:0] {
    D_NONE, D_U0, D_U1, D_U2, D_O0, D_O1, D_O2, D_Q0, D_Q1, D_Q2, D_Q3, D_DOT
  } dst_t;

  typedef struct packed {
    ctl_t            ctl;
    logic [PC_W-1:0] target;
    logic            term;
    logic [1:0]      asel;
    bsel_t           bsel;
    logic            neg;
    logic            first;
    logic            last;
    dst_t            dst;
    logic            sq_step;
    logic [1:0]      dist_idx;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic   accept;
    logic   busy;
    uword_t uw;
  } seq_ctrl_t;

  // program entry points
  localparam logic [PC_W-1:0] PC_ROT  = PC_W'(18);
  localparam logic [PC_W-1:0] PC_CONF = PC_W'(35);

  function automatic uword_t mk_term(input logic [1:0] a, input bsel_t b,
                                     input logic neg, input logic first,
                                     input logic last, input dst_t dst);
    uword_t w;
    w = '0;
    w.ctl   = CTL_NEXT;
    w.term  = 1'b1;
    w.asel  = a;
    w.bsel  = b;
    w.neg   = neg;
    w.first = first;
    w.last  = last;
    w.dst   = dst;
    return w;
  endfunction

  function automatic uword_t mk_ctl(input ctl_t ctl, input logic [PC_W-1:0] target);
    uword_t w;
    w = '0;
    w.ctl    = ctl;
    w.target = target;
    w.dst    = D_NONE;
    return w;
  endfunction

  function automatic uword_t mk_dist(input logic [1:0] idx);
    uword_t w;
    w = '0;
    w.ctl      = CTL_NEXT;
    w.dst      = D_NONE;
    w.sq_step  = 1'b1;
    w.dist_idx = idx;
    return w;
  endfunction

  // control store: one word per step
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      // dispatch
      6'd0:  w = mk_ctl(CTL_BR_INV, PC_ROT);
      6'd1:  w = mk_ctl(CTL_BR_CMP, PC_CONF);
      // quaternion product reference * input
      6'd2:  w = mk_term(2'd0, B_Q0, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd3:  w = mk_term(2'd1, B_Q1, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd4:  w = mk_term(2'd2, B_Q2, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd5:  w = mk_term(2'd3, B_Q3, 1'b1, 1'b0, 1'b1, D_Q0);
      6'd6:  w = mk_term(2'd0, B_Q1, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd7:  w = mk_term(2'd1, B_Q0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd8:  w = mk_term(2'd2, B_Q3, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd9:  w = mk_term(2'd3, B_Q2, 1'b1, 1'b0, 1'b1, D_Q1);
      6'd10: w = mk_term(2'd0, B_Q2, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd11: w = mk_term(2'd1, B_Q3, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd12: w = mk_term(2'd2, B_Q0, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd13: w = mk_term(2'd3, B_Q1, 1'b0, 1'b0, 1'b1, D_Q2);
      6'd14: w = mk_term(2'd0, B_Q3, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd15: w = mk_term(2'd1, B_Q2, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd16: w = mk_term(2'd2, B_Q1, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd17: w = mk_term(2'd3, B_Q0, 1'b0, 1'b0, 1'b1, D_Q3);
      // inner vector u = q x v + w v
      6'd18: w = mk_term(2'd2, B_T2, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd19: w = mk_term(2'd3, B_T1, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd20: w = mk_term(2'd0, B_T0, 1'b0, 1'b0, 1'b1, D_U0);
      6'd21: w = mk_term(2'd3, B_T0, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd22: w = mk_term(2'd1, B_T2, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd23: w = mk_term(2'd0, B_T1, 1'b0, 1'b0, 1'b1, D_U1);
      6'd24: w = mk_term(2'd1, B_T1, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd25: w = mk_term(2'd2, B_T0, 1'b1, 1'b0, 1'b0, D_NONE);
      6'd26: w = mk_term(2'd0, B_T2, 1'b0, 1'b0, 1'b1, D_U2);
      // wait for the last inner component to land
      6'd27: w = mk_ctl(CTL_NEXT, '0);
      // outer cross product q x u, written back as translation
      6'd28: w = mk_term(2'd2, B_U2, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd29: w = mk_term(2'd3, B_U1, 1'b1, 1'b0, 1'b1, D_O0);
      6'd30: w = mk_term(2'd3, B_U0, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd31: w = mk_term(2'd1, B_U2, 1'b1, 1'b0, 1'b1, D_O1);
      6'd32: w = mk_term(2'd1, B_U1, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd33: w = mk_term(2'd2, B_U0, 1'b1, 1'b0, 1'b1, D_O2);
      6'd34: w = mk_ctl(CTL_END, '0);
      // conflict test: dot product, then squared distance
      6'd35: w = mk_term(2'd0, B_Q0, 1'b0, 1'b1, 1'b0, D_NONE);
      6'd36: w = mk_term(2'd1, B_Q1, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd37: w = mk_term(2'd2, B_Q2, 1'b0, 1'b0, 1'b0, D_NONE);
      6'd38: w = mk_term(2'd3, B_Q3, 1'b0, 1'b0, 1'b1, D_DOT);
      6'd39: w = mk_dist(2'd0);
      6'd40: w = mk_dist(2'd1);
      6'd41: w = mk_dist(2'd2);
      6'd42: w = mk_ctl(CTL_NEXT, '0);
      6'd43: w = mk_ctl(CTL_END, '0);
      default: w = mk_ctl(CTL_END, '0);
    endcase
    return w;
  endfunction

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // saturated negation
  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == 32'sh80000000) r = 32'sh7fffffff;
    else r = -v;
    return r;
  endfunction

endpackage

### rtl/rpcc_sequencer.sv
// Microprogram sequencer: step counter, branch on operation, handshake control.
// Depends on rpcc_pkg for the control store and control word types.
module rpcc_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         operation,
  input  logic               out_stall,
  input  rpcc_pkg::op_t      op_q,
  output logic               in_stall,
  output logic               out_valid,
  output rpcc_pkg::seq_ctrl_t ctrl
);
  import rpcc_pkg::*;

  logic [PC_W-1:0] pc, pc_next;
  logic            busy, busy_next;
  logic            out_valid_next;
  logic            accept;
  uword_t          uw;

  assign uw       = ucode(pc);
  assign in_stall = busy | out_valid;
  assign accept   = in_valid & ~in_stall;

  assign ctrl.accept = accept;
  assign ctrl.busy   = busy;
  assign ctrl.uw     = uw;

  // next step, branches and completion
  always_comb begin
    pc_next        = pc;
    busy_next      = busy;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (accept) begin
      pc_next   = '0;
      busy_next = (op_t'(operation) != OP_LOAD);
    end else if (busy) begin
      case (uw.ctl)
        CTL_NEXT:   pc_next = pc + PC_W'(1);
        CTL_BR_INV: pc_next = (op_q == OP_INVERT) ? uw.target : pc + PC_W'(1);
        CTL_BR_CMP: pc_next = (op_q == OP_CONFLICT) ? uw.target : pc + PC_W'(1);
        CTL_END: begin
          busy_next      = 1'b0;
          out_valid_next = 1'b1;
        end
        default: pc_next = pc + PC_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pc        <= pc_next;
      busy      <= busy_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/rpcc_datapath.sv
// Datapath: pose registers, one shared multiplier with rounding accumulator,
// squared-distance unit, configuration registers and result registers.
// Depends on rpcc_pkg; steered by the control word from rpcc_sequencer.
module rpcc_datapath #(
  parameter int ROT_FRAC_BITS = rpcc_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rpcc_pkg::seq_ctrl_t ctrl,
  input  logic [1:0]          operation,
  input  logic signed [31:0]  in_tx,
  input  logic signed [31:0]  in_ty,
  input  logic signed [31:0]  in_tz,
  input  logic signed [31:0]  in_qw,
  input  logic signed [31:0]  in_qx,
  input  logic signed [31:0]  in_qy,
  input  logic signed [31:0]  in_qz,
  input  logic                cfg_wr,
  input  logic                cfg_index,
  input  logic [47:0]         cfg_data,
  output rpcc_pkg::op_t       op_q,
  output logic signed [31:0]  out_tx,
  output logic signed [31:0]  out_ty,
  output logic signed [31:0]  out_tz,
  output logic signed [31:0]  out_qw,
  output logic signed [31:0]  out_qx,
  output logic signed [31:0]  out_qy,
  output logic signed [31:0]  out_qz,
  output logic                too_far,
  output logic                too_turned
);
  import rpcc_pkg::*;

  localparam int TERM_W = 66 - ROT_FRAC_BITS;
  localparam int ACC_W  = TERM_W + 2;
  localparam logic signed [65:0] RoundHalf = 66'(1) <<< (ROT_FRAC_BITS - 1);
  localparam logic signed [31:0] QOne      = 32'(64'd1 << ROT_FRAC_BITS);

  uword_t uw;
  assign uw = ctrl.uw;

  // pose and configuration state
  logic signed [31:0] ref_t [3];
  logic signed [31:0] ref_q [4];
  logic [47:0]        dist_limit;
  logic [30:0]        min_dot;

  // operands of the current item
  logic signed [31:0] t_in [3];
  logic signed [31:0] q_in [4];
  logic signed [31:0] rq   [4];
  logic signed [32:0] u    [3];
  logic signed [31:0] in_conj [4];

  // multiplier stage
  logic signed [31:0] a_op;
  logic signed [32:0] b_op;
  logic signed [64:0] prod;
  logic               p_valid, p_neg, p_first, p_last;
  dst_t               p_dst;

  // accumulator and write-back
  logic signed [65:0]       prod_rnd;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc, acc_base, acc_next;
  logic signed [SAT_W-1:0]  wide, o_sum, o_fin, dot_abs;
  logic signed [31:0]       o_v, o_r, o_sat, acc_sat;
  logic signed [32:0]       u_val;
  logic                     turned_now;

  // distance unit
  logic signed [32:0] d_diff;
  logic [32:0]        d_mag;
  logic [47:0]        sq;
  logic               sq_add;
  logic [49:0]        dsum;
  logic               far_hit;

  assign in_conj[0] = in_qw;
  assign in_conj[1] = neg_sat(in_qx);
  assign in_conj[2] = neg_sat(in_qy);
  assign in_conj[3] = neg_sat(in_qz);

  // operand selection
  always_comb begin
    a_op = rq[uw.asel];
    case (uw.bsel)
      B_Q0:    b_op = 33'(q_in[0]);
      B_Q1:    b_op = 33'(q_in[1]);
      B_Q2:    b_op = 33'(q_in[2]);
      B_Q3:    b_op = 33'(q_in[3]);
      B_T0:    b_op = 33'(t_in[0]);
      B_T1:    b_op = 33'(t_in[1]);
      B_T2:    b_op = 33'(t_in[2]);
      B_U0:    b_op = u[0];
      B_U1:    b_op = u[1];
      B_U2:    b_op = u[2];
      default: b_op = '0;
    endcase
  end

  // round, accumulate and form the write-back values
  always_comb begin
    prod_rnd = 66'(prod) + RoundHalf;
    term     = TERM_W'(prod_rnd >>> ROT_FRAC_BITS);
    acc_base = p_first ? '0 : acc;
    acc_next = p_neg ? acc_base - ACC_W'(term) : acc_base + ACC_W'(term);
    wide     = SAT_W'(acc_next);
    acc_sat  = sat32(wide);
    case (p_dst)
      D_O1: begin
        o_v = t_in[1];
        o_r = ref_t[1];
      end
      D_O2: begin
        o_v = t_in[2];
        o_r = ref_t[2];
      end
      default: begin
        o_v = t_in[0];
        o_r = ref_t[0];
      end
    endcase
    o_sum = SAT_W'(o_v) + (wide <<< 1);
    o_fin = (op_q == OP_COMPOSE) ? o_sum + SAT_W'(o_r) : -o_sum;
    o_sat = sat32(o_fin);
    if (wide > INNER_MAX) u_val = 33'(INNER_MAX);
    else if (wide < -INNER_MAX) u_val = 33'(-INNER_MAX);
    else u_val = wide[32:0];
    dot_abs    = (wide < 0) ? -wide : wide;
    turned_now = dot_abs < SAT_W'(min_dot);
  end

  // difference magnitude for the current distance step
  always_comb begin
    case (uw.dist_idx)
      2'd1:    d_diff = 33'(ref_t[1]) - 33'(t_in[1]);
      2'd2:    d_diff = 33'(ref_t[2]) - 33'(t_in[2]);
      default: d_diff = 33'(ref_t[0]) - 33'(t_in[0]);
    endcase
    d_mag = (d_diff < 0) ? 33'(-d_diff) : 33'(d_diff);
  end

  // reference pose, configuration and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_t[0]   <= '0;
      ref_t[1]   <= '0;
      ref_t[2]   <= '0;
      ref_q[0]   <= QOne;
      ref_q[1]   <= '0;
      ref_q[2]   <= '0;
      ref_q[3]   <= '0;
      dist_limit <= 48'd65536;
      min_dot    <= 31'd1073578293;
      p_valid    <= 1'b0;
      sq_add     <= 1'b0;
      op_q       <= OP_LOAD;
    end else begin
      if (cfg_wr) begin
        if (cfg_index == CFG_DIST_LIMIT) dist_limit <= cfg_data;
        else min_dot <= cfg_data[30:0];
      end
      if (ctrl.accept) begin
        op_q <= op_t'(operation);
        if (op_t'(operation) == OP_LOAD) begin
          ref_t[0] <= in_tx;
          ref_t[1] <= in_ty;
          ref_t[2] <= in_tz;
          ref_q[0] <= in_qw;
          ref_q[1] <= in_qx;
          ref_q[2] <= in_qy;
          ref_q[3] <= in_qz;
        end
      end
      p_valid <= ctrl.busy & uw.term;
      sq_add  <= ctrl.busy & uw.sq_step;
    end
  end

  // operand capture, multiplier, accumulator and results
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      t_in[0] <= in_tx;
      t_in[1] <= in_ty;
      t_in[2] <= in_tz;
      q_in[0] <= in_qw;
      q_in[1] <= in_qx;
      q_in[2] <= in_qy;
      q_in[3] <= in_qz;
      for (int i = 0; i < 4; i++) begin
        rq[i] <= (op_t'(operation) == OP_INVERT) ? in_conj[i] : ref_q[i];
      end
      out_tx     <= '0;
      out_ty     <= '0;
      out_tz     <= '0;
      out_qw     <= (op_t'(operation) == OP_INVERT) ? in_conj[0] : '0;
      out_qx     <= (op_t'(operation) == OP_INVERT) ? in_conj[1] : '0;
      out_qy     <= (op_t'(operation) == OP_INVERT) ? in_conj[2] : '0;
      out_qz     <= (op_t'(operation) == OP_INVERT) ? in_conj[3] : '0;
      too_far    <= 1'b0;
      too_turned <= 1'b0;
      dsum       <= '0;
      far_hit    <= 1'b0;
    end else begin
      // one product per step
      if (ctrl.busy && uw.term) begin
        prod    <= 65'(a_op) * 65'(b_op);
        p_neg   <= uw.neg;
        p_first <= uw.first;
        p_last  <= uw.last;
        p_dst   <= uw.dst;
      end
      // accumulate and write back on the last term
      if (p_valid) begin
        acc <= acc_next;
        if (p_last) begin
          case (p_dst)
            D_U0:    u[0] <= u_val;
            D_U1:    u[1] <= u_val;
            D_U2:    u[2] <= u_val;
            D_O0:    out_tx <= o_sat;
            D_O1:    out_ty <= o_sat;
            D_O2:    out_tz <= o_sat;
            D_Q0:    out_qw <= acc_sat;
            D_Q1:    out_qx <= acc_sat;
            D_Q2:    out_qy <= acc_sat;
            D_Q3:    out_qz <= acc_sat;
            D_DOT:   too_turned <= turned_now;
            default: acc <= acc_next;
          endcase
        end
      end
      // squared distance, one axis a step
      if (ctrl.busy && uw.sq_step) begin
        if (|d_mag[32:24]) begin
          far_hit <= 1'b1;
          sq      <= '0;
        end else begin
          sq <= d_mag[23:0] * d_mag[23:0];
        end
      end
      if (sq_add) dsum <= dsum + 50'(sq);
      // final distance compare
      if (ctrl.busy && uw.ctl == CTL_END && op_q == OP_CONFLICT) begin
        too_far <= far_hit | (dsum > 50'(dist_limit));
      end
    end
  end

endmodule

### rtl/rigid_pose_compose_compare.sv
// Top level of the rigid-pose compose and compare unit.
// Depends on rpcc_pkg, rpcc_sequencer and rpcc_datapath.
//
// One item is worked at a time by a microprogram driving a single shared
// 32x33 multiplier, one product a cycle. A load gives no result; compose
// runs 16 quaternion terms and 15 rotation terms, invert the 15 rotation
// terms, and conflict test 4 dot terms plus 3 distance steps. A new item
// is taken once the previous result has been transferred.
// Configuration writes are always ready and belong in idle periods.
module rigid_pose_compose_compare #(
  parameter int ROT_FRAC_BITS = rpcc_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [31:0] in_tx,
  input  logic signed [31:0] in_ty,
  input  logic signed [31:0] in_tz,
  input  logic signed [31:0] in_qw,
  input  logic signed [31:0] in_qx,
  input  logic signed [31:0] in_qy,
  input  logic signed [31:0] in_qz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_tx,
  output logic signed [31:0] out_ty,
  output logic signed [31:0] out_tz,
  output logic signed [31:0] out_qw,
  output logic signed [31:0] out_qx,
  output logic signed [31:0] out_qy,
  output logic signed [31:0] out_qz,
  output logic               too_far,
  output logic               too_turned,
  output logic               conflict,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [47:0]        cfg_data
);
  import rpcc_pkg::*;

  seq_ctrl_t ctrl;
  op_t       op_q;

  assign cfg_ready = 1'b1;
  assign conflict  = too_far | too_turned;

  rpcc_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_stall (out_stall),
    .op_q      (op_q),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  rpcc_datapath #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .operation  (operation),
    .in_tx      (in_tx),
    .in_ty      (in_ty),
    .in_tz      (in_tz),
    .in_qw      (in_qw),
    .in_qx      (in_qx),
    .in_qy      (in_qy),
    .in_qz      (in_qz),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op_q       (op_q),
    .out_tx     (out_tx),
    .out_ty     (out_ty),
    .out_tz     (out_tz),
    .out_qw     (out_qw),
    .out_qx     (out_qx),
    .out_qy     (out_qy),
    .out_qz     (out_qz),
    .too_far    (too_far),
    .too_turned (too_turned)
  );

endmodule

### rtl/rpcc_checker.sv
// Port-level checks for the rigid-pose unit, bound to the top level.
// Depends on rpcc_pkg for operation codes.
module rpcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         operation,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_qw,
  input logic               too_far,
  input logic               too_turned,
  input logic               conflict
);
  import rpcc_pkg::*;

  // a working item blocks the input on the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op_t'(operation) != OP_LOAD) |=> in_stall)
    else $error("input not stalled after start of work");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op_t'(operation) == OP_LOAD) |=> !out_valid)
    else $error("result after load");

  // no transfer in while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // conflict flag consistent with its parts
  a_conflict_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (conflict == (too_far || too_turned)))
    else $error("conflict flag mismatch");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_qw)))
    else $error("stalled result changed");

endmodule

bind rigid_pose_compose_compare rpcc_checker u_chk (.*);
